// ===== hdl/lsmr_pkg.sv =====
// Package for the limit switch motor ramp block.
// Holds the item structs, register indexes and reset defaults; depends on nothing.
`default_nettype none

package lsmr_pkg;

    // Default scale of the PWM compare counts at full power.
    localparam int FULL_SCALE_DEFAULT = 1500;

    // Width of the configuration register index.
    localparam int CFG_INDEX_W = 3;

    // Command codes carried by a hardpoint command.
    localparam logic [15:0] CMD_LOWER = 16'd0;
    localparam logic [15:0] CMD_RAISE = 16'd1;

    // Input item kinds.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HARDPOINT_ADDRESS = 3'd0,
        CFG_DOWN_TARGET       = 3'd1,
        CFG_UP_TARGET         = 3'd2,
        CFG_DOWN_ACCEL_STEP   = 3'd3,
        CFG_UP_ACCEL_STEP     = 3'd4,
        CFG_DOWN_BRAKE_STEP   = 3'd5,
        CFG_UP_BRAKE_STEP     = 3'd6
    } t_cfg_reg;

    // Register reset values.
    localparam logic [7:0]         RST_HARDPOINT_ADDRESS = 8'd220;
    localparam logic [14:0]        RST_DOWN_TARGET       = 15'd9830;
    localparam logic signed [15:0] RST_UP_TARGET         = -16'sd19661;
    localparam logic [14:0]        RST_DOWN_ACCEL_STEP   = 15'd10;
    localparam logic [14:0]        RST_UP_ACCEL_STEP     = 15'd20;
    localparam logic [14:0]        RST_DOWN_BRAKE_STEP   = 15'd49;
    localparam logic [14:0]        RST_UP_BRAKE_STEP     = 15'd98;

    // One input item: a tick or a hardpoint command.
    typedef struct packed {
        logic        kind;
        logic [7:0]  target_hardpoint;
        logic [15:0] command_code;
        logic [6:0]  sender_id;
        logic        down_switch_open;
        logic        up_switch_open;
        logic        controller_alive;
    } t_in_item;

    // One result item: power, the two PWM duties and the direction.
    typedef struct packed {
        logic signed [15:0] motor_power;
        logic [10:0]        down_duty;
        logic [10:0]        up_duty;
        logic               going_up;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/limit_switch_motor_ramp.sv =====
// Top level of the limit switch motor ramp: command decode, power ramp and PWM split.
// Depends on lsmr_pkg for the item structs, register indexes and defaults.
`default_nettype none

// Soft-start drive for a DC motor running between an up and a down end switch.
// Each transfer on the input channel is either a 1 ms tick or a hardpoint command;
// every item gives exactly one result carrying the power, the two PWM duties and the
// direction as they stand after that item. The block takes one item per clock cycle
// while the result channel does not stall, and a result is offered once its item has
// passed an input register, a stage that updates direction and power, and a result
// register after the duty multiplier. Configuration writes are always ready and
// should only be issued while the block is idle.
module limit_switch_motor_ramp #(
    parameter int FULL_SCALE_COUNTS = lsmr_pkg::FULL_SCALE_DEFAULT
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // input item channel
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  lsmr_pkg::t_in_item                  i_data,
    // result channel
    output logic                                o_valid,
    input  wire                                 i_stall,
    output lsmr_pkg::t_out_item                 o_data,
    // configuration write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [lsmr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire  [15:0]                         i_cfg_data
);

    localparam logic [15:0] FullScale = 16'(FULL_SCALE_COUNTS);

    // Saturate a widened sum to the signed 16-bit power range.
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic [7:0]         r_hp_addr;
    logic [14:0]        r_down_target;
    logic signed [15:0] r_up_target;
    logic [14:0]        r_down_accel;
    logic [14:0]        r_up_accel;
    logic [14:0]        r_down_brake;
    logic [14:0]        r_up_brake;

    // Pipeline registers.
    logic               r_a_valid;
    lsmr_pkg::t_in_item r_a_item;
    logic               r_b_valid;
    logic signed [15:0] r_b_power;
    logic               r_b_dir;
    logic               r_c_valid;
    lsmr_pkg::t_out_item r_c_item;

    // Block state.
    logic               r_dir_up;
    logic signed [15:0] r_power;
    logic [6:0]         r_node;

    logic               n_dir_up;
    logic signed [15:0] n_power;
    logic [6:0]         n_node;

    logic               a_move;
    logic               b_move;

    // Stage handshakes: a stage advances when the next one is empty or emptying.
    assign b_move  = r_b_valid && (!r_c_valid || !i_stall);
    assign a_move  = r_a_valid && (!r_b_valid || b_move);
    assign o_stall = r_a_valid && !a_move;
    assign o_valid = r_c_valid;
    assign o_data  = r_c_item;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_addr     <= lsmr_pkg::RST_HARDPOINT_ADDRESS;
            r_down_target <= lsmr_pkg::RST_DOWN_TARGET;
            r_up_target   <= lsmr_pkg::RST_UP_TARGET;
            r_down_accel  <= lsmr_pkg::RST_DOWN_ACCEL_STEP;
            r_up_accel    <= lsmr_pkg::RST_UP_ACCEL_STEP;
            r_down_brake  <= lsmr_pkg::RST_DOWN_BRAKE_STEP;
            r_up_brake    <= lsmr_pkg::RST_UP_BRAKE_STEP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lsmr_pkg::CFG_HARDPOINT_ADDRESS: r_hp_addr     <= i_cfg_data[7:0];
                lsmr_pkg::CFG_DOWN_TARGET:       r_down_target <= i_cfg_data[14:0];
                lsmr_pkg::CFG_UP_TARGET:         r_up_target   <= i_cfg_data;
                lsmr_pkg::CFG_DOWN_ACCEL_STEP:   r_down_accel  <= i_cfg_data[14:0];
                lsmr_pkg::CFG_UP_ACCEL_STEP:     r_up_accel    <= i_cfg_data[14:0];
                lsmr_pkg::CFG_DOWN_BRAKE_STEP:   r_down_brake  <= i_cfg_data[14:0];
                lsmr_pkg::CFG_UP_BRAKE_STEP:     r_up_brake    <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_stall) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_a_item <= i_data;
        end
    end

    // Next state: command decode or one tick of the ramp.
    always_comb begin
        logic signed [17:0] p_ext;
        logic [16:0]        p_mag;
        logic signed [17:0] ut_ext;
        logic [16:0]        ut_mag;
        logic               dir_tick;
        n_dir_up = r_dir_up;
        n_power  = r_power;
        n_node   = r_node;
        p_ext    = {{2{r_power[15]}}, r_power};
        p_mag    = r_power[15] ? 17'(-p_ext) : 17'(p_ext);
        ut_ext   = {{2{r_up_target[15]}}, r_up_target};
        ut_mag   = r_up_target[15] ? 17'(-ut_ext) : 17'(ut_ext);
        dir_tick = r_dir_up;
        if (r_a_item.kind == lsmr_pkg::KIND_COMMAND) begin
            // Only a matching address with a raise or lower code is obeyed.
            if (r_a_item.target_hardpoint == r_hp_addr &&
                (r_a_item.command_code == lsmr_pkg::CMD_LOWER ||
                 r_a_item.command_code == lsmr_pkg::CMD_RAISE)) begin
                n_dir_up = r_a_item.command_code[0];
                n_node   = r_a_item.sender_id;
            end
        end else begin
            // A lost controller sends the motor up when a nonzero sender node is recorded.
            if (!r_a_item.controller_alive && r_node != 7'd0) begin
                dir_tick = 1'b1;
            end
            n_dir_up = dir_tick;
            if (!dir_tick) begin
                if (r_a_item.down_switch_open) begin
                    if (p_mag < {2'b00, r_down_target}) begin
                        n_power = sat16(p_ext + {3'b000, r_down_accel});
                    end else begin
                        n_power = {1'b0, r_down_target};
                    end
                end else begin
                    if (p_mag > {1'b0, r_down_brake, 1'b0}) begin
                        n_power = sat16(p_ext - {3'b000, r_down_brake});
                    end else begin
                        n_power = 16'sd0;
                    end
                end
            end else begin
                if (r_a_item.up_switch_open) begin
                    if (p_mag < ut_mag) begin
                        n_power = sat16(p_ext - {3'b000, r_up_accel});
                    end else begin
                        n_power = r_up_target;
                    end
                end else begin
                    if (p_mag > {1'b0, r_up_brake, 1'b0}) begin
                        n_power = sat16(p_ext + {3'b000, r_up_brake});
                    end else begin
                        n_power = 16'sd0;
                    end
                end
            end
        end
    end

    // State update and snapshot into the middle stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_up  <= 1'b1;
            r_power   <= 16'sd0;
            r_node    <= 7'd0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_move) begin
                r_dir_up <= n_dir_up;
                r_power  <= n_power;
                r_node   <= n_node;
            end
            if (a_move) begin
                r_b_valid <= 1'b1;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_power <= n_power;
            r_b_dir   <= n_dir_up;
        end
    end

    // Duty split: scale the magnitude and saturate to the 11-bit compare range.
    logic signed [16:0] b_ext;
    logic [15:0]        b_mag;
    logic [31:0]        b_prod;
    logic [16:0]        b_scaled;
    logic [10:0]        b_duty;

    assign b_ext    = {r_b_power[15], r_b_power};
    assign b_mag    = r_b_power[15] ? 16'(-b_ext) : r_b_power;
    assign b_prod   = FullScale * b_mag;
    assign b_scaled = b_prod[31:15];
    assign b_duty   = (b_scaled > 17'd2047) ? 11'd2047 : b_scaled[10:0];

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (b_move) begin
            r_c_valid <= 1'b1;
        end else if (!i_stall) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_c_item.motor_power <= r_b_power;
            r_c_item.down_duty   <= (!r_b_power[15] && r_b_power != 16'sd0) ? b_duty : 11'd0;
            r_c_item.up_duty     <= r_b_power[15] ? b_duty : 11'd0;
            r_c_item.going_up    <= r_b_dir;
        end
    end

    // Only one drive channel is ever active in a result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.down_duty == 11'd0 || o_data.up_duty == 11'd0))
        else $error("both PWM duties active in one result");

    // Zero power gives no drive on either channel.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.motor_power == 16'sd0) |->
        (o_data.down_duty == 11'd0 && o_data.up_duty == 11'd0))
        else $error("duty present with zero power");

    // The input side only stalls when its register holds an item that cannot advance.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && r_b_valid && r_c_valid && i_stall))
        else $error("input stalled with room downstream");

    // An item in the input register with the middle stage empty moves on at once.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_b_valid) |=> r_b_valid)
        else $error("item did not advance into an empty stage");

    // Power only changes when an item passes the update stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(a_move) |-> $stable(r_power))
        else $error("power changed without an item");

endmodule

`default_nettype wire
